>>> rtl/lsr_pkg.sv
// ----------------------------------------------------------------------------
// lsr_pkg: shared types and constants of the setpoint ramp generator
// Register indexes, sequencer states, adder request and result bundles.
// ----------------------------------------------------------------------------
package lsr_pkg;

   // width of the shared adder operands
   localparam int ALU_W = 49;

   // configuration register indexes
   localparam logic [1:0] CSR_START  = 2'd0;
   localparam logic [1:0] CSR_TARGET = 2'd1;
   localparam logic [1:0] CSR_TIME   = 2'd2;

   // request kinds
   localparam logic CMD_COMPUTE = 1'b0;
   localparam logic CMD_RESTART = 1'b1;

   // last iteration indexes of the serial divider and multiplier
   localparam logic [5:0] DIV_LAST = 6'd48;
   localparam logic [5:0] MUL_LAST = 6'd31;

   // slope magnitude limits, Q16.32, for a rising and a falling ramp
   localparam logic [48:0] SLOPE_POS_LIM = 49'h0_7FFF_FFFF_FFFF;
   localparam logic [48:0] SLOPE_NEG_LIM = 49'h0_8000_0000_0000;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIFF,
      ST_MAG,
      ST_DIV,
      ST_SLOPE,
      ST_ELAPSED,
      ST_MUL,
      ST_CMP,
      ST_OFFSET,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic             sub;
      logic [ALU_W-1:0] a;
      logic [ALU_W-1:0] b;
   } alu_req_type;

   typedef struct packed {
      logic             carry;
      logic [ALU_W-1:0] sum;
   } alu_rsp_type;

endpackage

>>> rtl/lsr_alu.sv
// ----------------------------------------------------------------------------
// lsr_alu: shared adder and subtractor
// Adds or subtracts two operands; the carry out is set on a subtract
// when no borrow occurs.
// ----------------------------------------------------------------------------
module lsr_alu (
   input  lsr_pkg::alu_req_type req,
   output lsr_pkg::alu_rsp_type rsp
);

   logic [lsr_pkg::ALU_W-1:0] b_op;
   logic [lsr_pkg::ALU_W:0]   total;

   assign b_op  = req.sub ? ~req.b : req.b;
   assign total = {1'b0, req.a} + {1'b0, b_op} + {{lsr_pkg::ALU_W{1'b0}}, req.sub};

   assign rsp.carry = total[lsr_pkg::ALU_W];
   assign rsp.sum   = total[lsr_pkg::ALU_W-1:0];

endmodule

>>> rtl/linear_setpoint_ramp.sv
// ----------------------------------------------------------------------------
// linear_setpoint_ramp: linear setpoint ramp generator
// Moves a Q16.16 setpoint from a start to a target value over a set time,
// with the slope found by a serial divider and the setpoint by a serial
// multiplier, both on one shared adder.
// ----------------------------------------------------------------------------
//
//  channel  dir  payload                                   handshake
//  -------  ---  ----------------------------------------  --------------
//  req_     in   tdata now_ms[31:0], tuser command         tvalid/tready
//  rsp_     out  tdata value[31:0], tuser {error, active}  tvalid/tready
//  csr_     in   addr index, wdata register value          we, no stall
//
//  A restart item gives no result and leaves the block ready. The first
//  compute item after a restart runs the 49-step restoring divider; later
//  compute items run the 32-step shift-and-add multiplier, and skip the
//  offset step once the ramp has passed the target. An invalid setup
//  answers without running either.
//  Reset clears the sequencer, the started mark and the output valid.
//  A result waits in the output register; the next item is taken while
//  it waits, and the sequencer holds its next result until the slot frees.
//
module linear_setpoint_ramp (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] now_ms
   input  logic        req_tuser,   // [0] command
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] value
   output logic [1:0]  rsp_tuser,   // [0] active, [1] config_error
   // configuration port
   input  logic        csr_we,
   input  logic [1:0]  csr_addr,
   input  logic [31:0] csr_wdata
);

   // configuration registers
   logic [31:0] start_ff, target_ff, time_ff;

   // sequencer
   lsr_pkg::state_type state_ff, state_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [31:0] now_ff, now_in;

   // working registers
   logic [32:0] diff_ff, diff_in;     // target - start, signed
   logic [32:0] dmag_ff, dmag_in;     // |target - start|
   logic        dneg_ff, dneg_in;
   logic [31:0] rem_ff, rem_in;       // divider remainder
   logic [48:0] quo_ff, quo_in;       // dividend shifting out, quotient in
   logic [79:0] prod_ff, prod_in;     // {accumulator, multiplier}

   // ramp state
   logic        started_ff, started_in;
   logic [31:0] start_time_ff, start_time_in;
   logic        slope_neg_ff, slope_neg_in;
   logic [47:0] slope_mag_ff, slope_mag_in;

   // result slot
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_value_ff, rsp_value_in;
   logic        rsp_active_ff, rsp_active_in;
   logic        rsp_err_ff, rsp_err_in;

   // pending result from the sequencer
   logic [31:0] res_value_ff, res_value_in;
   logic        res_active_ff, res_active_in;
   logic        res_err_ff, res_err_in;

   lsr_pkg::alu_req_type alu_req;
   lsr_pkg::alu_rsp_type alu_rsp;

   logic req_take;
   logic slot_free;

   lsr_alu u_alu (
      .req (alu_req),
      .rsp (alu_rsp)
   );

   assign req_tready = (state_ff == lsr_pkg::ST_IDLE);
   assign req_take   = req_tvalid && req_tready;
   assign slot_free  = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_value_ff;
   assign rsp_tuser  = {rsp_err_ff, rsp_active_ff};

   // configuration writes; an index beyond the list is dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff  <= '0;
         target_ff <= '0;
         time_ff   <= '0;
      end else if (csr_we) begin
         case (csr_addr)
            lsr_pkg::CSR_START:  start_ff  <= csr_wdata;
            lsr_pkg::CSR_TARGET: target_ff <= csr_wdata;
            lsr_pkg::CSR_TIME:   time_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= lsr_pkg::ST_IDLE;
         started_ff    <= 1'b0;
         start_time_ff <= '0;
         slope_neg_ff  <= 1'b0;
         slope_mag_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         started_ff    <= started_in;
         start_time_ff <= start_time_in;
         slope_neg_ff  <= slope_neg_in;
         slope_mag_ff  <= slope_mag_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      cnt_ff        <= cnt_in;
      now_ff        <= now_in;
      diff_ff       <= diff_in;
      dmag_ff       <= dmag_in;
      dneg_ff       <= dneg_in;
      rem_ff        <= rem_in;
      quo_ff        <= quo_in;
      prod_ff       <= prod_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_active_ff <= rsp_active_in;
      rsp_err_ff    <= rsp_err_in;
      res_value_ff  <= res_value_in;
      res_active_ff <= res_active_in;
      res_err_ff    <= res_err_in;
   end

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      now_in        = now_ff;
      diff_in       = diff_ff;
      dmag_in       = dmag_ff;
      dneg_in       = dneg_ff;
      rem_in        = rem_ff;
      quo_in        = quo_ff;
      prod_in       = prod_ff;
      started_in    = started_ff;
      start_time_in = start_time_ff;
      slope_neg_in  = slope_neg_ff;
      slope_mag_in  = slope_mag_ff;
      res_value_in  = res_value_ff;
      res_active_in = res_active_ff;
      res_err_in    = res_err_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_active_in = rsp_active_ff;
      rsp_err_in    = rsp_err_ff;
      // drop the result once taken
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;

      alu_req.sub = 1'b1;
      alu_req.a   = '0;
      alu_req.b   = '0;

      case (state_ff)
         lsr_pkg::ST_IDLE: begin
            if (req_take) begin
               now_in = req_tdata;
               if (req_tuser == lsr_pkg::CMD_RESTART) begin
                  started_in = 1'b0;
               end else begin
                  state_in = lsr_pkg::ST_DIFF;
               end
            end
         end

         // signed distance from start to target
         lsr_pkg::ST_DIFF: begin
            alu_req.a = {{17{target_ff[31]}}, target_ff};
            alu_req.b = {{17{start_ff[31]}}, start_ff};
            diff_in   = alu_rsp.sum[32:0];
            state_in  = lsr_pkg::ST_MAG;
         end

         // magnitude and validity; seed the divider
         lsr_pkg::ST_MAG: begin
            alu_req.a = '0;
            alu_req.b = {{16{diff_ff[32]}}, diff_ff};
            dneg_in   = diff_ff[32];
            dmag_in   = diff_ff[32] ? alu_rsp.sum[32:0] : diff_ff;
            quo_in    = {dmag_in, 16'h0000};
            rem_in    = '0;
            cnt_in    = '0;
            if (diff_ff == '0 || time_ff == '0) begin
               res_value_in  = target_ff;
               res_active_in = 1'b0;
               res_err_in    = 1'b1;
               state_in      = lsr_pkg::ST_OUT;
            end else if (!started_ff) begin
               state_in = lsr_pkg::ST_DIV;
            end else begin
               state_in = lsr_pkg::ST_ELAPSED;
            end
         end

         // restoring division, one quotient bit a cycle
         lsr_pkg::ST_DIV: begin
            alu_req.a = {16'h0000, rem_ff, quo_ff[48]};
            alu_req.b = {17'h00000, time_ff};
            if (alu_rsp.carry) begin
               rem_in = alu_rsp.sum[31:0];
               quo_in = {quo_ff[47:0], 1'b1};
            end else begin
               rem_in = {rem_ff[30:0], quo_ff[48]};
               quo_in = {quo_ff[47:0], 1'b0};
            end
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == lsr_pkg::DIV_LAST) begin
               state_in = lsr_pkg::ST_SLOPE;
            end
         end

         // clamp the slope, latch the start time, answer with the start value
         lsr_pkg::ST_SLOPE: begin
            slope_neg_in = dneg_ff;
            if (!dneg_ff && quo_ff > lsr_pkg::SLOPE_POS_LIM) begin
               slope_mag_in = lsr_pkg::SLOPE_POS_LIM[47:0];
            end else if (dneg_ff && quo_ff > lsr_pkg::SLOPE_NEG_LIM) begin
               slope_mag_in = lsr_pkg::SLOPE_NEG_LIM[47:0];
            end else begin
               slope_mag_in = quo_ff[47:0];
            end
            start_time_in = now_ff;
            started_in    = 1'b1;
            res_value_in  = start_ff;
            res_active_in = 1'b1;
            res_err_in    = 1'b0;
            state_in      = lsr_pkg::ST_OUT;
         end

         // elapsed time, modulo 2^32; seed the multiplier
         lsr_pkg::ST_ELAPSED: begin
            alu_req.a = {17'h00000, now_ff};
            alu_req.b = {17'h00000, start_time_ff};
            prod_in   = {48'h0, alu_rsp.sum[31:0]};
            cnt_in    = '0;
            state_in  = lsr_pkg::ST_MUL;
         end

         // shift-and-add multiply, one multiplier bit a cycle
         lsr_pkg::ST_MUL: begin
            alu_req.sub = 1'b0;
            alu_req.a   = {1'b0, prod_ff[79:32]};
            alu_req.b   = {1'b0, slope_mag_ff};
            if (prod_ff[0]) begin
               prod_in = {alu_rsp.sum, prod_ff[31:1]};
            end else begin
               prod_in = {1'b0, prod_ff[79:32], prod_ff[31:1]};
            end
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == lsr_pkg::MUL_LAST) begin
               state_in = lsr_pkg::ST_CMP;
            end
         end

         // passed the target when the offset exceeds the distance
         lsr_pkg::ST_CMP: begin
            alu_req.a = {dmag_ff, 16'h0000};
            alu_req.b = prod_ff[48:0];
            if ((|slope_mag_ff) && ((|prod_ff[79:49]) || !alu_rsp.carry)) begin
               res_value_in  = target_ff;
               res_active_in = 1'b0;
               res_err_in    = 1'b0;
               state_in      = lsr_pkg::ST_OUT;
            end else begin
               state_in = lsr_pkg::ST_OFFSET;
            end
         end

         // apply the truncated offset in the slope's direction
         lsr_pkg::ST_OFFSET: begin
            alu_req.sub   = slope_neg_ff;
            alu_req.a     = {{17{start_ff[31]}}, start_ff};
            alu_req.b     = {17'h00000, prod_ff[47:16]};
            res_value_in  = alu_rsp.sum[31:0];
            res_active_in = 1'b1;
            res_err_in    = 1'b0;
            state_in      = lsr_pkg::ST_OUT;
         end

         // hold until the output slot frees
         lsr_pkg::ST_OUT: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = res_value_ff;
               rsp_active_in = res_active_ff;
               rsp_err_in    = res_err_ff;
               state_in      = lsr_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = lsr_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

>>> rtl/lsr_checker.sv
// ----------------------------------------------------------------------------
// lsr_checker: port-level checks of the setpoint ramp generator
// Watches the request and result channels of the top level.
// ----------------------------------------------------------------------------
module lsr_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic [1:0]  rsp_tuser
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // a configuration error never reports a moving ramp
   a_err_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> !rsp_tuser[0])
      else $error("config error with active ramp");

   // reset empties the output
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // a restart gives no result
   a_restart_silent: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser && !rsp_tvalid |=> !rsp_tvalid)
      else $error("restart produced a result");

   // a compute item keeps the block busy
   a_compute_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !req_tuser |=> !req_tready)
      else $error("ready straight after a compute item");

endmodule

bind linear_setpoint_ramp lsr_checker u_lsr_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

>>> verif/linear_setpoint_ramp_tb.sv
// ----------------------------------------------------------------------------
// linear_setpoint_ramp_tb: self-checking bench for the setpoint ramp generator
// Drives restart and compute items over the request stream with bursty
// timing, stalls the result stream on changing patterns, and checks every
// result against an in-bench ramp predictor across many register settings.
// ----------------------------------------------------------------------------
module linear_setpoint_ramp_tb;

   localparam int CLK_PERIOD    = 12;
   localparam int MAX_CYCLES    = 1_000_000;
   localparam int RANDOM_ITEMS  = 900;
   localparam int SETTLE_CYCLES = 60;    // covers the slowest item, a fresh slope
   localparam int DRAIN_LIMIT   = 5000;
   localparam int REPORT_LIMIT  = 10;

   // index 3 maps to no register; writes there must be dropped
   localparam logic [1:0] CSR_SPARE = 2'd3;

   // slope limits in Q16.32 per ms
   localparam logic [63:0] RATE_MAX = 64'h0000_7FFF_FFFF_FFFF;
   localparam logic [47:0] RATE_MIN = 48'h8000_0000_0000;

   typedef struct {
      logic        cmd;
      logic [31:0] now;
      bit          pause;   // marker: hold the stream until all results are back
   } ramp_req_type;

   typedef struct {
      logic [31:0] value;
      logic        active;
      logic        cfg_err;
   } setpoint_type;

   typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_COMB} rx_mode_type;

   // DUT ports; the ones the bench drives are known from time zero
   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;       // [31:0] now_ms
   logic        req_tuser  = lsr_pkg::CMD_COMPUTE; // [0] command
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;             // [31:0] value
   logic [1:0]  rsp_tuser;             // [0] active, [1] config_error
   logic        csr_we     = 1'b0;
   logic [1:0]  csr_addr   = lsr_pkg::CSR_START;
   logic [31:0] csr_wdata  = '0;

   // predictor copy of the registers and the ramp state
   logic [31:0]        cfg_start  = '0;
   logic [31:0]        cfg_target = '0;
   logic [31:0]        cfg_time   = '0;
   logic               ramp_live  = 1'b0;
   logic [31:0]        ramp_t0    = '0;
   logic signed [47:0] ramp_rate  = '0;

   ramp_req_type req_q[$];        // items waiting to be driven
   setpoint_type setpoint_q[$];   // setpoints predicted, not yet seen

   int fail_count   = 0;
   int queued_items = 0;
   int taken_items  = 0;
   int taken_resets = 0;
   int n_moving     = 0;
   int n_arrived    = 0;
   int n_refused    = 0;
   int settings     = 1;
   int gap_left     = 0;
   int burst_left   = 0;
   int rx_cycle     = 0;
   rx_mode_type rx_mode = RX_OPEN;

   linear_setpoint_ramp u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   // Hard stop: a hung handshake must not run forever.
   initial begin
      #(CLK_PERIOD * MAX_CYCLES);
      $display("linear_setpoint_ramp test failed");
      $finish;
   end

   // --------------------------------------------------------------------------
   // Ramp predictor: advance the ramp by one accepted item and push the
   // setpoint it should produce. Restarts only clear the started mark.
   // --------------------------------------------------------------------------
   function automatic void ramp_advance(input logic cmd, input logic [31:0] now);
      longint       span;
      logic [63:0]  span_mag;
      logic [63:0]  span_q16;
      logic [63:0]  quot;
      logic [63:0]  rate_mag;
      logic [31:0]  elapsed;
      logic [79:0]  travel;
      logic [31:0]  level;
      setpoint_type sp;
      span     = longint'($signed(cfg_target)) - longint'($signed(cfg_start));
      span_mag = (span < 0) ? 64'(-span) : 64'(span);
      span_q16 = span_mag << 16;
      if (cmd == lsr_pkg::CMD_RESTART) begin
         ramp_live = 1'b0;
         return;
      end
      if (span == 0 || cfg_time == 0) begin
         // refused setup: report the target, leave the ramp state alone
         sp = '{cfg_target, 1'b0, 1'b1};
      end else if (!ramp_live) begin
         // first compute after a restart: latch time and slope, emit the start
         quot = span_q16 / {32'd0, cfg_time};
         if (span > 0)
            ramp_rate = (quot > RATE_MAX) ? RATE_MAX[47:0] : quot[47:0];
         else
            ramp_rate = (quot > RATE_MAX + 64'd1) ? RATE_MIN : -quot[47:0];
         ramp_t0   = now;
         ramp_live = 1'b1;
         sp = '{cfg_start, 1'b1, 1'b0};
      end else begin
         elapsed  = now - ramp_t0;
         rate_mag = ramp_rate[47] ? {16'd0, -ramp_rate} : {16'd0, ramp_rate};
         travel   = 80'(rate_mag) * 80'(elapsed);
         if (rate_mag != 0 && travel > 80'(span_q16)) begin
            sp = '{cfg_target, 1'b0, 1'b0};
         end else begin
            // offset truncated to Q16.16, applied in the slope's direction
            level = ramp_rate[47] ? cfg_start - travel[47:16] : cfg_start + travel[47:16];
            sp = '{level, 1'b1, 1'b0};
         end
      end
      setpoint_q.push_back(sp);
   endfunction

   function automatic void report_fault(input string what, input setpoint_type want,
                                        input setpoint_type got);
      fail_count++;
      if (fail_count <= REPORT_LIMIT)
         $display("%0t %s: expected value %h active %b error %b, got value %h active %b error %b",
                  $time, what, want.value, want.active, want.cfg_err,
                  got.value, got.active, got.cfg_err);
   endfunction

   function automatic logic [31:0] pick_level();
      case ($urandom_range(0, 5))
         0:       return 32'h8000_0000;
         1:       return 32'h7FFF_FFFF;
         2:       return 32'h0000_0000;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [31:0] pick_duration();
      case ($urandom_range(0, 11))
         0:       return 32'd0;
         1:       return 32'd1;
         2:       return 32'hFFFF_FFFF;
         3:       return $urandom;
         default: return $urandom_range(2, 500);
      endcase
   endfunction

   task automatic push_req(input logic cmd, input logic [31:0] now);
      req_q.push_back('{cmd, now, 1'b0});
      queued_items++;
   endtask

   // Write one register; the predictor follows the same decode.
   task automatic write_csr(input logic [1:0] idx, input logic [31:0] data);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         lsr_pkg::CSR_START:  cfg_start  = data;
         lsr_pkg::CSR_TARGET: cfg_target = data;
         lsr_pkg::CSR_TIME:   cfg_time   = data;
         default:    ;
      endcase
   endtask

   // Drain everything, then allow the block to finish any restart still
   // inside it. Results that never show up are failures, then dropped.
   task automatic settle();
      int waited;
      waited = 0;
      while (req_q.size() != 0 || req_tvalid) @(posedge clock);
      while (setpoint_q.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      while (setpoint_q.size() != 0)
         report_fault("result never came", setpoint_q.pop_front(), '{32'bx, 1'bx, 1'bx});
   endtask

   // --------------------------------------------------------------------------
   // Request driver: feed items from req_q in bursts with idle gaps. A pause
   // marker at the head holds the stream until every result is back.
   // --------------------------------------------------------------------------
   always @(posedge clock) begin : sender
      ramp_req_type nxt;
      logic         send;
      if (reset) begin
         req_tvalid <= 1'b0;
         gap_left   = 0;
         burst_left = 0;
      end else begin
         // predict on acceptance, using exactly what the block took
         if (req_tvalid && req_tready) begin
            ramp_advance(req_tuser, req_tdata);
            taken_items++;
            if (req_tuser == lsr_pkg::CMD_RESTART) taken_resets++;
         end
         if (!req_tvalid || req_tready) begin
            send = 1'b0;
            if (req_q.size() != 0 && req_q[0].pause) begin
               if (setpoint_q.size() == 0) void'(req_q.pop_front());
            end else if (gap_left > 0) begin
               gap_left--;
            end else if (req_q.size() != 0) begin
               nxt  = req_q.pop_front();
               send = 1'b1;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  // new burst: sometimes long and flat out, gaps mostly short
                  burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                           : $urandom_range(0, 8);
                  gap_left   = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 90)
                                                           : $urandom_range(0, 6);
               end
            end
            // one assignment per edge: valid stays high across back-to-back items
            req_tvalid <= send;
            if (send) begin
               req_tuser <= nxt.cmd;
               req_tdata <= nxt.now;
            end
         end
      end
   end

   // --------------------------------------------------------------------------
   // Result receiver: the ready pattern is redrawn from time to time among
   // always open, coin toss, sparse and a fixed comb.
   // --------------------------------------------------------------------------
   always @(posedge clock) begin : receiver
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rx_cycle++;
         if (rx_cycle % 300 == 0) rx_mode = rx_mode_type'($urandom_range(0, 3));
         case (rx_mode)
            RX_OPEN:   rsp_tready <= 1'b1;
            RX_COIN:   rsp_tready <= 1'($urandom_range(0, 1));
            RX_SPARSE: rsp_tready <= ($urandom_range(0, 9) == 0);
            default:   rsp_tready <= ((rx_cycle % 7) < 3);
         endcase
      end
   end

   // Compare each accepted result with the oldest prediction.
   always @(posedge clock) begin : result_check
      setpoint_type got;
      setpoint_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '{rsp_tdata, rsp_tuser[0], rsp_tuser[1]};
         if (got.cfg_err)     n_refused++;
         else if (got.active) n_moving++;
         else                 n_arrived++;
         if (setpoint_q.size() == 0) begin
            report_fault("unexpected result", '{32'bx, 1'bx, 1'bx}, got);
         end else begin
            want = setpoint_q.pop_front();
            if (got.value !== want.value || got.active !== want.active ||
                got.cfg_err !== want.cfg_err)
               report_fault("setpoint mismatch", want, got);
         end
      end
   end

   // --------------------------------------------------------------------------
   // Stimulus: directed corners first, then random register settings, each
   // followed by mostly well-formed ramps and some noise.
   // --------------------------------------------------------------------------
   initial begin
      logic [31:0] lvl_a;
      logic [31:0] lvl_b;
      logic [31:0] dur;
      logic [31:0] t;
      int          random_goal;
      int          phase_end;
      int          steps;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Registers at reset: start equals target and duration is zero, so
      // every compute is refused. Also restart while never started.
      push_req(lsr_pkg::CMD_COMPUTE, 32'h0000_0000);
      push_req(lsr_pkg::CMD_RESTART, 32'h0000_0000);
      push_req(lsr_pkg::CMD_COMPUTE, 32'hFFFF_FFFF);
      settle();

      // Full-scale rise in one ms: slope saturates high. Hold time steady,
      // step by one, then wrap the clock past zero.
      write_csr(lsr_pkg::CSR_START,  32'h8000_0000);
      write_csr(lsr_pkg::CSR_TARGET, 32'h7FFF_FFFF);
      write_csr(lsr_pkg::CSR_TIME,   32'd1);
      settings++;
      push_req(lsr_pkg::CMD_RESTART, 32'h1234_5678);
      push_req(lsr_pkg::CMD_COMPUTE, 32'hFFFF_FFF0);
      push_req(lsr_pkg::CMD_COMPUTE, 32'hFFFF_FFF0);
      push_req(lsr_pkg::CMD_COMPUTE, 32'hFFFF_FFF1);
      push_req(lsr_pkg::CMD_COMPUTE, 32'hFFFF_FFF2);
      push_req(lsr_pkg::CMD_COMPUTE, 32'h0000_0005);
      settle();

      // Full-scale fall in one ms: slope saturates low; largest elapsed time.
      write_csr(lsr_pkg::CSR_START,  32'h7FFF_FFFF);
      write_csr(lsr_pkg::CSR_TARGET, 32'h8000_0000);
      settings++;
      push_req(lsr_pkg::CMD_RESTART, 32'hFFFF_FFFF);
      push_req(lsr_pkg::CMD_COMPUTE, 32'h0000_0000);
      push_req(lsr_pkg::CMD_COMPUTE, 32'h0000_0001);
      push_req(lsr_pkg::CMD_COMPUTE, 32'hFFFF_FFFF);
      settle();

      // One LSB over the longest duration: slope truncates to zero and the
      // ramp never arrives, even after the longest wait.
      write_csr(lsr_pkg::CSR_START,  32'h0000_0000);
      write_csr(lsr_pkg::CSR_TARGET, 32'h0000_0001);
      write_csr(lsr_pkg::CSR_TIME,   32'hFFFF_FFFF);
      settings++;
      push_req(lsr_pkg::CMD_RESTART, 32'd0);
      push_req(lsr_pkg::CMD_COMPUTE, 32'd7);
      push_req(lsr_pkg::CMD_COMPUTE, 32'd6);
      settle();

      // Retarget mid-ramp: the slope stays latched, the new target applies.
      // A write to the spare index must leave every register untouched.
      write_csr(lsr_pkg::CSR_START,  32'h0001_0000);
      write_csr(lsr_pkg::CSR_TARGET, 32'h0005_0000);
      write_csr(lsr_pkg::CSR_TIME,   32'd4);
      settings++;
      push_req(lsr_pkg::CMD_RESTART, 32'd0);
      push_req(lsr_pkg::CMD_COMPUTE, 32'd1000);
      push_req(lsr_pkg::CMD_COMPUTE, 32'd1002);
      settle();
      write_csr(lsr_pkg::CSR_TARGET, 32'h0002_0000);
      write_csr(CSR_SPARE,  32'hA5A5_5A5A);
      push_req(lsr_pkg::CMD_COMPUTE, 32'd1003);
      settle();
      // zero duration while started: refused, state kept
      write_csr(lsr_pkg::CSR_TIME, 32'd0);
      settings++;
      push_req(lsr_pkg::CMD_COMPUTE, 32'd1004);
      settle();

      random_goal = queued_items + RANDOM_ITEMS;
      while (queued_items < random_goal) begin
         // new setting; now and then start equals target
         lvl_a = pick_level();
         lvl_b = ($urandom_range(0, 11) == 0) ? lvl_a : pick_level();
         dur   = pick_duration();
         write_csr(lsr_pkg::CSR_START,  lvl_a);
         write_csr(lsr_pkg::CSR_TARGET, lvl_b);
         write_csr(lsr_pkg::CSR_TIME,   dur);
         if ($urandom_range(0, 3) == 0) write_csr(CSR_SPARE, $urandom);
         settings++;

         phase_end = queued_items + $urandom_range(40, 90);
         while (queued_items < phase_end) begin
            case ($urandom_range(0, 19))
               0, 1, 2: begin
                  // noise: a lone item of either kind at any time
                  push_req(1'($urandom_range(0, 1)), $urandom);
               end
               3: begin
                  req_q.push_back('{lsr_pkg::CMD_COMPUTE, 32'd0, 1'b1});
               end
               default: begin
                  // a ramp run: restart (mostly), latch, then rising times
                  // sized so the run usually passes the target part-way
                  steps = $urandom_range(2, 20);
                  if ($urandom_range(0, 5) != 0) push_req(lsr_pkg::CMD_RESTART, $urandom);
                  t = $urandom;
                  push_req(lsr_pkg::CMD_COMPUTE, t);
                  repeat (steps) begin
                     if ($urandom_range(0, 9) == 0) t = t + $urandom;
                     else t = t + $urandom_range(0, (dur >> 3) + 1);
                     // a stray restart breaks the run now and then
                     if ($urandom_range(0, 14) == 0) push_req(lsr_pkg::CMD_RESTART, t);
                     push_req(lsr_pkg::CMD_COMPUTE, t);
                  end
               end
            endcase
         end
         settle();
      end

      $display("Ran %0d items (%0d restarts) through %0d register settings.",
               taken_items, taken_resets, settings);
      $display("Checked results: %0d moving, %0d at target, %0d refused setups, %0d faults.",
               n_moving, n_arrived, n_refused, fail_count);
      if (fail_count == 0) begin
         $display("linear_setpoint_ramp test passed");
      end else begin
         $display("linear_setpoint_ramp test failed");
      end
      $finish;
   end

endmodule
